// ===== src/gnss_time_to_utc_calendar_macros.svh =====
// ---------------------------------------------------------------------------
// gnss_time_to_utc_calendar_macros
// Assertion shorthands for the time-to-calendar block.
// ---------------------------------------------------------------------------
`ifndef GNSS_TIME_TO_UTC_CALENDAR_MACROS_SVH
`define GNSS_TIME_TO_UTC_CALENDAR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GTUC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("gtuc assertion failed");

// Check a property on every clock edge, reset included.
`define GTUC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("gtuc assertion failed during reset");

`endif

// ===== src/gtuc_pkg.sv =====
// ---------------------------------------------------------------------------
// gtuc_pkg
// Types, constants and tables shared by the time-to-calendar block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gtuc_pkg;

   localparam int LEAP_TABLE_ENTRIES = 18;
   localparam int BUILTIN_LEAPS      = 18;
   localparam int LEAP_USED = (LEAP_TABLE_ENTRIES > BUILTIN_LEAPS) ? BUILTIN_LEAPS :
                              ((LEAP_TABLE_ENTRIES < 0) ? 0 : LEAP_TABLE_ENTRIES);

   localparam int NUM_STAGES = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index of leap_second_enable
   localparam logic [0:0] REG_LEAP_ENABLE = 1'b0;

   typedef enum logic [1:0] {
      TS_GPS     = 2'd0,
      TS_BEIDOU  = 2'd1,
      TS_GALILEO = 2'd2,
      TS_SPARE   = 2'd3
   } time_sys_type;

   localparam logic [30:0] LEAP_INSTANTS [0:BUILTIN_LEAPS-1] = '{
      31'd46828800,   31'd78364801,   31'd109900802,  31'd173059203,
      31'd252028804,  31'd315187205,  31'd346723206,  31'd393984007,
      31'd425520008,  31'd457056009,  31'd504489610,  31'd551750411,
      31'd599184012,  31'd820108813,  31'd914803214,  31'd1025136015,
      31'd1119744016, 31'd1167264017
   };

   localparam logic [8:0] MONTH_START [0:11] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // one word in flight, carried through every stage
   typedef struct packed {
      logic [15:0] sub;
      logic [13:0] week;
      logic [30:0] msw;
      logic [19:0] q1000;
      logic [33:0] wsec;
      logic [33:0] gps;
      logic [4:0]  adj;
      logic        at_leap;
      logic [30:0] r;
      logic [4:0]  qd;
      logic [16:0] week7;
      logic [26:0] msday;
      logic [16:0] dp;
      logic [5:0]  cycd;
      logic [16:0] secs;
      logic [10:0] rem;
      logic        feb29;
      logic [9:0]  ms;
      logic [4:0]  hour;
      logic [11:0] year;
      logic [11:0] rs;
      logic [5:0]  minute;
      logic [3:0]  month;
      logic [4:0]  dom;
      logic [5:0]  sec;
      logic        oor;
   } item_type;

endpackage
`default_nettype wire

// ===== src/gtuc_req_if.sv =====
// ---------------------------------------------------------------------------
// gtuc_req_if
// Input channel: GNSS time word with valid/ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface gtuc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  time_system;
   logic [12:0] week_number;
   logic [29:0] millisecond_of_week;
   logic [15:0] sub_millisecond;

   modport source (output valid, time_system, week_number, millisecond_of_week,
                   sub_millisecond, input ready);
   modport sink   (input valid, time_system, week_number, millisecond_of_week,
                   sub_millisecond, output ready);
endinterface

// ---------------------------------------------------------------------------
// gtuc_rsp_if
// Result channel: UTC calendar word with valid/ready.
// ---------------------------------------------------------------------------
interface gtuc_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  whole_second;
   logic [9:0]  millisecond;
   logic [15:0] sub_ms_out;
   logic        out_of_range;

   modport source (output valid, year, month, day_of_month, hour, minute,
                   whole_second, millisecond, sub_ms_out, out_of_range, input ready);
   modport sink   (input valid, year, month, day_of_month, hour, minute,
                   whole_second, millisecond, sub_ms_out, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== src/gnss_time_to_utc_calendar.sv =====
// ---------------------------------------------------------------------------
// gnss_time_to_utc_calendar
// GPS / BeiDou / Galileo week time to UTC calendar date, leap seconds applied.
// ---------------------------------------------------------------------------
// One word enters each cycle while the pipeline is not stalled. The pipeline
// is twelve register stages, each holding at most two constant-reciprocal
// multiplies, and the last stage is the output register. A stall on the
// result side holds the whole pipeline. BeiDou adds 1356 weeks and 14000 ms,
// Galileo 1024 weeks, code 3 is GPS. The leap count comes from an 18-entry
// table compared in parallel; with leap_second_enable set, an instant on a
// table entry reads second 60. Years outside 1984..2099 raise out_of_range.
// Register 0 (byte address 0) is leap_second_enable, reset 1.
`timescale 1ns / 1ps
`default_nettype none
module gnss_time_to_utc_calendar (
   input  wire logic                                clock,
   input  wire logic                                reset,
   gtuc_req_if.sink                                 req_chan,
   gtuc_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [gtuc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [gtuc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [gtuc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   localparam int N = gtuc_pkg::NUM_STAGES;

   // reciprocal multipliers, each exact over its input range
   localparam logic [30:0] RECIP_MSW_1000 = 31'd1099511628; // 2^40 / 1000
   localparam logic [21:0] RECIP_DAY      = 22'd3257813;    // 2^38 / 84375
   localparam logic [17:0] RECIP_CYCLE    = 18'd183735;     // 2^28 / 1461
   localparam logic [27:0] RECIP_SEC_1000 = 28'd137438954;  // 2^37 / 1000
   localparam logic [17:0] RECIP_HOUR     = 18'd149131;     // 2^29 / 3600
   localparam logic [12:0] RECIP_MIN      = 13'd4370;       // 2^18 / 60

   logic                 leap_en_ff, leap_en_in;
   logic                 csr_wr;
   logic [N-1:0]         vld_ff, vld_in;
   gtuc_pkg::item_type   st_ff [N];
   gtuc_pkg::item_type   st_in [N];
   logic                 adv;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      leap_en_in = leap_en_ff;
      if (csr_wr && (csr_paddr[2] == gtuc_pkg::REG_LEAP_ENABLE)) begin
         leap_en_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == gtuc_pkg::REG_LEAP_ENABLE) begin
         csr_prdata[0] = leap_en_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leap_en_ff <= 1'b1;
      end else begin
         leap_en_ff <= leap_en_in;
      end
   end

   // ---------------- pipeline control ----------------
   // Advance every stage together unless the output word is held.
   assign adv            = !vld_ff[N-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      vld_in = {vld_ff[N-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   // ---------------- stage logic ----------------
   logic [60:0] p_msw;
   logic [42:0] p_day;
   logic [34:0] p_cyc;
   logic [54:0] p_sec;
   logic [34:0] p_hour;
   logic [23:0] p_min;
   logic [4:0]  leap_cnt;
   logic        leap_hit;
   logic [10:0] rem_v;
   logic [11:0] year_v;
   logic        feb29_v;
   logic [3:0]  mon_v;
   logic [5:0]  sec_v;

   always_comb begin
      st_in[0] = '0;
      for (int k = 1; k < N; k++) begin
         st_in[k] = st_ff[k-1];
      end

      // stage 1: move source time onto GPS time; the ms sum may pass 30 bits
      st_in[0].sub  = req_chan.sub_millisecond;
      st_in[0].week = {1'b0, req_chan.week_number};
      st_in[0].msw  = {1'b0, req_chan.millisecond_of_week};
      case (gtuc_pkg::time_sys_type'(req_chan.time_system))
         gtuc_pkg::TS_BEIDOU: begin
            st_in[0].week = {1'b0, req_chan.week_number} + 14'd1356;
            st_in[0].msw  = {1'b0, req_chan.millisecond_of_week} + 31'd14000;
         end
         gtuc_pkg::TS_GALILEO: begin
            st_in[0].week = {1'b0, req_chan.week_number} + 14'd1024;
         end
         default: begin
            st_in[0].week = {1'b0, req_chan.week_number};
         end
      endcase

      // stage 2: whole seconds of week and seconds of weeks
      p_msw          = 61'(st_ff[0].msw) * 61'(RECIP_MSW_1000);
      st_in[1].q1000 = p_msw[59:40];
      st_in[1].wsec  = 34'(st_ff[0].week) * 34'(604800);

      // stage 3: GPS seconds
      st_in[2].gps = st_ff[1].wsec + 34'(st_ff[1].q1000);

      // stage 4: leap table lookup, all entries compared at once
      leap_cnt = '0;
      leap_hit = 1'b0;
      for (int i = 0; i < gtuc_pkg::LEAP_USED; i++) begin
         if (st_ff[2].gps > 34'(gtuc_pkg::LEAP_INSTANTS[i])) begin
            leap_cnt = leap_cnt + 5'd1;
         end
         if (st_ff[2].gps == 34'(gtuc_pkg::LEAP_INSTANTS[i])) begin
            leap_hit = 1'b1;
         end
      end
      st_in[3].adj     = leap_en_ff ? (leap_cnt + 5'(leap_hit)) : 5'd0;
      st_in[3].at_leap = leap_en_ff && leap_hit;

      // stage 5: ms of week plus one week of padding, minus leap ms
      st_in[4].r = 31'(st_ff[3].msw) + 31'd604800000 - 31'(st_ff[3].adj) * 31'd1000;

      // stage 6: day within padded week (86400000 = 2^10 * 84375), up to 19
      p_day          = 43'(st_ff[4].r[30:10]) * 43'(RECIP_DAY);
      st_in[5].qd    = p_day[42:38];
      st_in[5].week7 = 17'(st_ff[4].week) * 17'd7;

      // stage 7: ms of day, and day count from 1 Jan 1976 so that it stays positive
      st_in[6].msday = 27'(st_ff[5].r - 31'(st_ff[5].qd) * 31'd86400000);
      st_in[6].dp    = st_ff[5].week7 + 17'(st_ff[5].qd) + 17'd1459;

      // stage 8: four-year cycle and whole seconds of day
      p_cyc          = 35'(st_ff[6].dp) * 35'(RECIP_CYCLE);
      st_in[7].cycd  = p_cyc[33:28];
      p_sec          = 55'(st_ff[6].msday) * 55'(RECIP_SEC_1000);
      st_in[7].secs  = p_sec[53:37];

      // stage 9: day within cycle, ms of second, hour
      st_in[8].rem  = 11'(st_ff[7].dp - 17'(st_ff[7].cycd) * 17'd1461);
      st_in[8].ms   = 10'(st_ff[7].msday - 27'(st_ff[7].secs) * 27'd1000);
      p_hour        = 35'(st_ff[7].secs) * 35'(RECIP_HOUR);
      st_in[8].hour = p_hour[33:29];

      // stage 10: year within cycle, fold out Feb 29
      rem_v   = st_ff[8].rem;
      year_v  = 12'd1976 + 12'(st_ff[8].cycd) * 12'd4;
      feb29_v = 1'b0;
      if (rem_v >= 11'd1096) begin
         rem_v  = rem_v - 11'd1096;
         year_v = year_v + 12'd3;
      end else if (rem_v >= 11'd731) begin
         rem_v  = rem_v - 11'd731;
         year_v = year_v + 12'd2;
      end else if (rem_v >= 11'd366) begin
         rem_v  = rem_v - 11'd366;
         year_v = year_v + 12'd1;
      end else if (rem_v >= 11'd60) begin
         rem_v  = rem_v - 11'd1;
      end else if (rem_v == 11'd59) begin
         feb29_v = 1'b1;
      end
      st_in[9].rem   = rem_v;
      st_in[9].year  = year_v;
      st_in[9].feb29 = feb29_v;
      st_in[9].rs    = 12'(st_ff[8].secs - 17'(st_ff[8].hour) * 17'd3600);

      // stage 11: month and day, minute
      mon_v = 4'd12;
      for (int i = 11; i >= 1; i--) begin
         if (st_ff[9].rem < 11'(gtuc_pkg::MONTH_START[i])) begin
            mon_v = 4'(i);
         end
      end
      if (st_ff[9].feb29) begin
         st_in[10].month = 4'd2;
         st_in[10].dom   = 5'd29;
      end else begin
         st_in[10].month = mon_v;
         st_in[10].dom   = 5'(st_ff[9].rem - 11'(gtuc_pkg::MONTH_START[mon_v - 4'd1])
                              + 11'd1);
      end
      p_min            = 24'(st_ff[9].rs) * 24'(RECIP_MIN);
      st_in[10].minute = p_min[23:18];

      // stage 12 (output register): second, leap second, range flag
      sec_v            = 6'(st_ff[10].rs - 12'(st_ff[10].minute) * 12'd60);
      st_in[11].sec    = sec_v + 6'(st_ff[10].at_leap);
      st_in[11].oor    = (st_ff[10].year < 12'd1984) || (st_ff[10].year > 12'd2099);
   end

   // ---------------- result word ----------------
   assign rsp_chan.valid        = vld_ff[N-1];
   assign rsp_chan.year         = st_ff[N-1].year;
   assign rsp_chan.month        = st_ff[N-1].month;
   assign rsp_chan.day_of_month = st_ff[N-1].dom;
   assign rsp_chan.hour         = st_ff[N-1].hour;
   assign rsp_chan.minute       = st_ff[N-1].minute;
   assign rsp_chan.whole_second = st_ff[N-1].sec;
   assign rsp_chan.millisecond  = st_ff[N-1].ms;
   assign rsp_chan.sub_ms_out   = st_ff[N-1].sub;
   assign rsp_chan.out_of_range = st_ff[N-1].oor;

   // ---------------- assertions ----------------
`include "gnss_time_to_utc_calendar_macros.svh"

   `GTUC_ASSERT_ALWAYS(a_flush_on_reset, reset |=> !rsp_chan.valid)
   `GTUC_ASSERT(a_month_legal, rsp_chan.valid |-> (rsp_chan.month >= 4'd1 && rsp_chan.month <= 4'd12 && rsp_chan.day_of_month >= 5'd1))
   `GTUC_ASSERT(a_range_flag, (rsp_chan.valid && !rsp_chan.out_of_range) |-> (rsp_chan.year >= 12'd1984 && rsp_chan.year <= 12'd2099))
   `GTUC_ASSERT(a_no_leap_when_off, (rsp_chan.valid && !leap_en_ff) |-> rsp_chan.whole_second <= 6'd59)

endmodule
`default_nettype wire
